@@ design/lbpp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lbpp_pkg;

  // Default sizes of the duration table.
  localparam int MAX_STEPS_DEF     = 64;
  localparam int DURATION_BITS_DEF = 16;

  // Width of a step index as it appears on the input channel.
  localparam int STEP_IDX_W = 6;
  // Width of the mask registers.
  localparam int MASK_W     = 64;
  // Width of the configuration register index.
  localparam int CFG_IDX_W  = 3;

  // Request kinds carried on the input channel.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_START = 2'd2
  } lbpp_op_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BUZZER_MASK    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN_MASK     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_MASK       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_ENABLE  = 3'd4;

  // Access to the duration table: one write and one read address per cycle.
  typedef struct packed {
    logic                  wr_en;
    logic [STEP_IDX_W-1:0] wr_addr;
    logic [STEP_IDX_W-1:0] rd_addr;
  } lbpp_mem_req_t;

  // One result; buzzer_on lands in the lowest bit when packed.
  typedef struct packed {
    logic playing;
    logic red_on;
    logic green_on;
    logic buzzer_on;
  } lbpp_result_t;

endpackage

`default_nettype wire

@@ design/lbpp_dur_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lbpp_dur_ram #(
  parameter int DEPTH = lbpp_pkg::MAX_STEPS_DEF,
  parameter int DW    = lbpp_pkg::DURATION_BITS_DEF,
  parameter int AW    = $clog2(lbpp_pkg::MAX_STEPS_DEF)
) (
  input  wire                     clk,
  input  lbpp_pkg::lbpp_mem_req_t req,
  input  wire  [DW-1:0]           wr_data,
  output logic [DW-1:0]           rd_data
);

  logic [DW-1:0] mem [0:DEPTH-1];

  // Write port.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[AW-1:0]] <= wr_data;
    end
  end

  // Registered read port; a write to the same entry in the same cycle is passed through.
  always_ff @(posedge clk) begin
    if (req.wr_en && (req.wr_addr == req.rd_addr)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[req.rd_addr[AW-1:0]];
    end
  end

endmodule

`default_nettype wire

@@ design/lbpp_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lbpp_seq #(
  parameter int MAX_STEPS = lbpp_pkg::MAX_STEPS_DEF,
  parameter int DW        = lbpp_pkg::DURATION_BITS_DEF,
  parameter int PW        = $clog2(lbpp_pkg::MAX_STEPS_DEF + 1)
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  go,
  input  lbpp_pkg::lbpp_op_t                   op,
  input  wire  [lbpp_pkg::STEP_IDX_W-1:0]      step_index,
  input  wire  [15:0]                          duration,
  input  wire  [lbpp_pkg::MASK_W-1:0]          buzzer_mask,
  input  wire  [lbpp_pkg::MASK_W-1:0]          green_mask,
  input  wire  [lbpp_pkg::MASK_W-1:0]          red_mask,
  input  wire  [lbpp_pkg::STEP_IDX_W-1:0]      pattern_length,
  input  wire                                  repeat_enable,
  input  wire  [DW-1:0]                        rd_data,
  output lbpp_pkg::lbpp_mem_req_t              mem_req,
  output logic [DW-1:0]                        wr_data,
  output lbpp_pkg::lbpp_result_t               result
);

  // pos is the current step plus one, so zero means before the first step.
  logic [PW-1:0] pos, pos_next;
  logic          pending, pending_next;
  logic [DW-1:0] elapsed, elapsed_next;
  logic          active, active_next;
  logic [2:0]    levels, levels_next;    // {red, green, buzzer}
  logic [DW-1:0] dur_cur, dur_cur_next;  // duration of the current step

  logic [PW-1:0] end_pos;
  logic [6:0]    end_idx;
  logic          wr_ok;

  // Last step index: the configured length, held inside the table.
  always_comb begin
    if ({1'b0, pattern_length} > 7'(MAX_STEPS - 1)) begin
      end_idx = 7'(MAX_STEPS - 1);
    end else begin
      end_idx = {1'b0, pattern_length};
    end
    end_pos = PW'(end_idx);
  end

  assign wr_ok   = ({1'b0, step_index} < 7'(MAX_STEPS));
  assign wr_data = DW'(duration);

  // Next state for one request.
  always_comb begin
    logic          adv;
    logic [PW-1:0] pos_a;
    logic [2:0]    lv_a;
    logic [DW-1:0] el_a;
    logic [DW-1:0] dur_c;
    logic [5:0]    mi;

    pos_next     = pos;
    pending_next = pending;
    elapsed_next = elapsed;
    active_next  = active;
    levels_next  = levels;
    dur_cur_next = dur_cur;
    mem_req.wr_en   = 1'b0;
    mem_req.wr_addr = step_index;

    adv   = pending;
    mi    = 6'(pos);
    pos_a = adv ? (pos + PW'(1)) : pos;
    lv_a  = adv ? {red_mask[mi], green_mask[mi], buzzer_mask[mi]} : levels;
    if (adv) begin
      el_a = '0;
    end else if (elapsed == {DW{1'b1}}) begin
      el_a = elapsed;
    end else begin
      el_a = elapsed + DW'(1);
    end
    dur_c = adv ? rd_data : dur_cur;

    if (go) begin
      unique case (op)
        lbpp_pkg::OP_TICK: begin
          if (active) begin
            dur_cur_next = dur_c;
            pos_next     = pos_a;
            levels_next  = lv_a;
            elapsed_next = el_a;
            pending_next = 1'b0;
            if (pos_a > end_pos) begin
              // Past the last step: stop dark or start over.
              if (!repeat_enable) begin
                levels_next = 3'b000;
                active_next = 1'b0;
              end else begin
                pos_next     = '0;
                pending_next = 1'b1;
              end
            end else if (el_a >= dur_c) begin
              pending_next = 1'b1;
              elapsed_next = '0;
            end
          end
        end
        lbpp_pkg::OP_WRITE: begin
          if (wr_ok) begin
            mem_req.wr_en = 1'b1;
            // Keep the held duration current when its own entry is rewritten.
            if ((8'(step_index) + 8'd1) == 8'(pos)) begin
              dur_cur_next = wr_data;
            end
          end
        end
        lbpp_pkg::OP_START: begin
          pos_next     = '0;
          pending_next = 1'b1;
          elapsed_next = '0;
          active_next  = 1'b1;
        end
        default: begin
        end
      endcase
    end

    // Prefetch the duration of the step that follows the current one.
    mem_req.rd_addr = 6'(pos_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      pending <= 1'b1;
      elapsed <= '0;
      active  <= 1'b0;
      levels  <= 3'b000;
    end else begin
      pos     <= pos_next;
      pending <= pending_next;
      elapsed <= elapsed_next;
      active  <= active_next;
      levels  <= levels_next;
    end
  end

  always_ff @(posedge clk) begin
    dur_cur <= dur_cur_next;
  end

  // Result reflects the state after this request.
  always_comb begin
    result.playing   = active_next;
    result.red_on    = levels_next[2];
    result.green_on  = levels_next[1];
    result.buzzer_on = levels_next[0];
  end

endmodule

`default_nettype wire

@@ design/led_buzzer_pattern_player_unit.sv @@
// LED and buzzer pattern player.
// Input channel (s_*): one request per transfer. s_tuser selects the kind:
// a millisecond tick, a write of one step duration, or a start request.
// Output channel (m_*): exactly one result per request, giving the buzzer,
// green and red drive levels and the playing flag after that request.
// Configuration port: cfg_we, cfg_index and cfg_data write the three step
// masks, the pattern length and the repeat flag. The user must write them
// only while the block is idle; the block itself does not enforce this. Throughput is
// one request per cycle while the receiver takes each result. The step durations sit in
// a table memory with a registered read; the following step's duration is fetched ahead,
// so back-to-back ticks never wait for the memory. Each result is registered.
// A result waiting on a stalled receiver is held in the output register;
// a new request is taken in the cycle the receiver takes that result.
// Synchronous reset clears the registers and playback state and empties
// the output register; the duration table holds nothing meaningful until
// each entry is written.
`timescale 1ns / 1ps
`default_nettype none

module led_buzzer_pattern_player_unit #(
  parameter int MAX_STEPS     = lbpp_pkg::MAX_STEPS_DEF,
  parameter int DURATION_BITS = lbpp_pkg::DURATION_BITS_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  // Request channel.
  input  wire                               s_tvalid,
  output logic                              s_tready,
  input  wire  [23:0]                       s_tdata,   // step_index[5:0], duration[21:6]
  input  wire  [1:0]                        s_tuser,   // op[1:0]
  // Result channel.
  output logic                              m_tvalid,
  input  wire                               m_tready,
  output logic [7:0]                        m_tdata,   // buzzer_on, green_on, red_on, playing
  // Configuration writes.
  input  wire                               cfg_we,
  input  wire  [lbpp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [lbpp_pkg::MASK_W-1:0]       cfg_data
);

  localparam int AW = $clog2(MAX_STEPS);
  localparam int PW = $clog2(MAX_STEPS + 1);

  logic [lbpp_pkg::MASK_W-1:0]     buzzer_mask;
  logic [lbpp_pkg::MASK_W-1:0]     green_mask;
  logic [lbpp_pkg::MASK_W-1:0]     red_mask;
  logic [lbpp_pkg::STEP_IDX_W-1:0] pattern_length;
  logic                            repeat_enable;

  logic                    go;
  lbpp_pkg::lbpp_mem_req_t mem_req;
  logic [DURATION_BITS-1:0] wr_data;
  logic [DURATION_BITS-1:0] rd_data;
  lbpp_pkg::lbpp_result_t  result;
  lbpp_pkg::lbpp_result_t  out_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      buzzer_mask    <= '0;
      green_mask     <= '0;
      red_mask       <= '0;
      pattern_length <= '0;
      repeat_enable  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lbpp_pkg::CFG_BUZZER_MASK:    buzzer_mask    <= cfg_data;
        lbpp_pkg::CFG_GREEN_MASK:     green_mask     <= cfg_data;
        lbpp_pkg::CFG_RED_MASK:       red_mask       <= cfg_data;
        lbpp_pkg::CFG_PATTERN_LENGTH: pattern_length <= cfg_data[lbpp_pkg::STEP_IDX_W-1:0];
        lbpp_pkg::CFG_REPEAT_ENABLE:  repeat_enable  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // A request is taken whenever the output register is free or being emptied.
  assign s_tready = !m_tvalid || m_tready;
  assign go       = s_tvalid && s_tready;

  lbpp_seq #(
    .MAX_STEPS (MAX_STEPS),
    .DW        (DURATION_BITS),
    .PW        (PW)
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .go             (go),
    .op             (lbpp_pkg::lbpp_op_t'(s_tuser)),
    .step_index     (s_tdata[5:0]),
    .duration       (s_tdata[21:6]),
    .buzzer_mask    (buzzer_mask),
    .green_mask     (green_mask),
    .red_mask       (red_mask),
    .pattern_length (pattern_length),
    .repeat_enable  (repeat_enable),
    .rd_data        (rd_data),
    .mem_req        (mem_req),
    .wr_data        (wr_data),
    .result         (result)
  );

  lbpp_dur_ram #(
    .DEPTH (MAX_STEPS),
    .DW    (DURATION_BITS),
    .AW    (AW)
  ) u_dur_ram (
    .clk     (clk),
    .req     (mem_req),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_data <= result;
    end
  end

  assign m_tdata = {4'b0000, out_data};

`ifndef ASSERT_OFF
  // Every accepted request produces a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> m_tvalid)
    else $error("accepted request produced no result");

  // A start request always reports playback as active.
  a_start_plays: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser == lbpp_pkg::OP_START)) |=> m_tdata[3])
    else $error("start request did not report playing");

  // While stopped, every output is dark.
  a_stopped_dark: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[3]) |-> (m_tdata[2:0] == 3'b000))
    else $error("outputs driven while not playing");
`endif

endmodule

`default_nettype wire
